FILE: sv/fts_pkg.sv
// fts_pkg: shared types and constants of the round-robin thread scheduler
// holds opcode, status and state encodings plus the fixed payload widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fts_pkg;

  // fixed payload widths
  localparam int OPCODE_W     = 3;
  localparam int THREAD_ID_W  = 4;
  localparam int SEM_INDEX_W  = 3;
  localparam int INIT_VALUE_W = 8;
  localparam int STATUS_W     = 3;

  // default sizing
  localparam int DEF_MAX_THREADS    = 16;
  localparam int DEF_NUM_SEMAPHORES = 8;
  localparam int DEF_COUNT_WIDTH    = 8;

  // event opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_LAUNCH  = 3'd0,
    OP_START   = 3'd1,
    OP_RELINQ  = 3'd2,
    OP_EXIT    = 3'd3,
    OP_WAIT    = 3'd4,
    OP_SIGNAL  = 3'd5,
    OP_INIT    = 3'd6
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_NO_THREADS  = 3'd1,
    STAT_READY_EMPTY = 3'd2,
    STAT_DEADLOCK    = 3'd3,
    STAT_DUPLICATE   = 3'd4,
    STAT_SATURATED   = 3'd5,
    STAT_HALTED      = 3'd6
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAKE
  } state_e;

endpackage

`default_nettype wire

FILE: sv/fts_intf.sv
// fts_intf: valid/ready channels of the thread scheduler
// event channel into the block and result channel out of it
// depends on fts_pkg for the payload widths
`timescale 1ns / 1ps
`default_nettype none

interface fts_evt_if;
  logic                               valid;
  logic                               ready;
  logic [fts_pkg::OPCODE_W-1:0]       opcode;
  logic [fts_pkg::THREAD_ID_W-1:0]    thread_id;
  logic [fts_pkg::SEM_INDEX_W-1:0]    sem_index;
  logic [fts_pkg::INIT_VALUE_W-1:0]   init_value;

  modport source (output valid, opcode, thread_id, sem_index, init_value, input ready);
  modport sink   (input valid, opcode, thread_id, sem_index, init_value, output ready);
endinterface

interface fts_res_if;
  logic                               valid;
  logic                               ready;
  logic [fts_pkg::THREAD_ID_W-1:0]    running_thread;
  logic                               running_valid;
  logic                               switched;
  logic [fts_pkg::STATUS_W-1:0]       status;

  modport source (output valid, running_thread, running_valid, switched, status,
                  input ready);
  modport sink   (input valid, running_thread, running_valid, switched, status,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/fifo_thread_scheduler_semaphores.sv
// Round-robin thread scheduler with counting semaphores.
// Channels: evt_i takes one event beat (launch, start, relinquish, exit,
// wait, signal, semaphore init); res_o gives exactly one result beat per
// event with the running thread, a switch flag and a status code.
// Thread queues are linked lists in a next-pointer RAM; semaphore records
// (count, head, tail, empty) live in a second RAM. Both read synchronously.
// Sequence: an accepted event reads both RAMs, then does the read-modify-write
// and registers its result; a signal that wakes a waiter adds a WAKE state,
// as the link RAM is read a second time at the semaphore queue head.
// Events are not overlapped: a new event is taken only once the previous
// one has committed its read-then-write sequence on the two RAMs.
// A new event is taken while the previous result still sits in the output
// register; if the receiver stalls, the block holds its finished event and
// stops taking new beats until the output register frees up.
// Reset: all queues empty, semaphore counts zero, no thread running, not
// halted. Semaphore records are marked valid per entry, so no clearing pass
// is needed. After a crisis error every event reports halted until reset.
`timescale 1ns / 1ps
`default_nettype none

module fifo_thread_scheduler_semaphores #(
  parameter int MAX_THREADS    = fts_pkg::DEF_MAX_THREADS,
  parameter int NUM_SEMAPHORES = fts_pkg::DEF_NUM_SEMAPHORES,
  parameter int COUNT_WIDTH    = fts_pkg::DEF_COUNT_WIDTH
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  fts_evt_if.sink     evt_i,
  fts_res_if.source   res_o
);

  localparam int TW   = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int SW   = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int CW   = COUNT_WIDTH;
  localparam int TidW = fts_pkg::THREAD_ID_W;
  localparam int OpW  = fts_pkg::OPCODE_W;
  localparam int IvW  = fts_pkg::INIT_VALUE_W;

  typedef struct packed {
    logic [CW-1:0] count;
    logic [TW-1:0] head;
    logic [TW-1:0] tail;
    logic          empty;
  } sem_rec_t;

  localparam sem_rec_t SemReset = '{count: '0, head: '0, tail: '0, empty: 1'b1};

  // sequencer
  fts_pkg::state_e state_q, state_d;

  // captured event
  logic [OpW-1:0] ev_op_q;
  logic [TW-1:0]  ev_tid_q;
  logic           ev_tid_ok_q;
  logic [SW-1:0]  ev_si_q;
  logic           ev_si_ok_q;
  logic [IvW-1:0] ev_iv_q;

  // scheduler registers
  logic [TW-1:0]          ready_head_q, ready_head_d;
  logic [TW-1:0]          ready_tail_q, ready_tail_d;
  logic                   ready_empty_q, ready_empty_d;
  logic [TW-1:0]          cur_q, cur_d;
  logic                   cur_valid_q, cur_valid_d;
  logic                   halted_q, halted_d;
  logic [MAX_THREADS-1:0] live_q, live_d;
  logic [NUM_SEMAPHORES-1:0] sem_vld_q;

  // memories
  logic [TW-1:0] link_mem [MAX_THREADS];
  logic [TW-1:0] link_rdata_q;
  sem_rec_t      sem_mem [NUM_SEMAPHORES];
  sem_rec_t      sem_rdata_q;
  logic          sem_hit_q;

  // output register
  logic            out_valid_q;
  logic [TidW-1:0] out_thread_q;
  logic            out_rvalid_q;
  logic            out_sw_q;
  fts_pkg::status_e out_status_q;

  // control
  logic          accept;
  logic          in_tid_ok;
  logic          in_si_ok;
  logic          wake;
  logic          done;
  logic          out_free;
  logic          commit;
  logic          link_re;
  logic [TW-1:0] link_raddr;
  logic          sem_re;
  logic [SW-1:0] sem_raddr;

  // datapath results
  sem_rec_t         sem_cur;
  sem_rec_t         sem_wd;
  logic             sem_we;
  logic             lk_we;
  logic [TW-1:0]    lk_wa;
  logic [TW-1:0]    lk_wd;
  fts_pkg::status_e status_c;
  logic             sw_c;

  assign in_tid_ok = 32'(evt_i.thread_id) < 32'(MAX_THREADS);
  assign in_si_ok  = 32'(evt_i.sem_index) < 32'(NUM_SEMAPHORES);
  assign accept    = evt_i.valid && evt_i.ready;
  assign out_free  = !out_valid_q || res_o.ready;
  assign sem_cur   = sem_hit_q ? sem_rdata_q : SemReset;

  // a signal with a nonempty wait queue needs the link of its head
  assign wake = !halted_q && (ev_op_q == fts_pkg::OP_SIGNAL) && ev_si_ok_q && !sem_cur.empty;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fts_pkg::S_IDLE: begin
        if (accept) state_d = fts_pkg::S_EXEC;
      end
      fts_pkg::S_EXEC: begin
        if (wake) state_d = fts_pkg::S_WAKE;
        else if (out_free) state_d = fts_pkg::S_IDLE;
      end
      fts_pkg::S_WAKE: begin
        if (out_free) state_d = fts_pkg::S_IDLE;
      end
      default: state_d = fts_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    evt_i.ready = 1'b0;
    done        = 1'b0;
    link_re     = 1'b0;
    link_raddr  = ready_head_q;
    sem_re      = 1'b0;
    sem_raddr   = SW'(evt_i.sem_index);
    case (state_q)
      fts_pkg::S_IDLE: begin
        evt_i.ready = 1'b1;
        link_re     = evt_i.valid;
        sem_re      = evt_i.valid && in_si_ok;
      end
      fts_pkg::S_EXEC: begin
        done       = !wake;
        link_re    = wake;
        link_raddr = sem_cur.head;
      end
      fts_pkg::S_WAKE: begin
        done = 1'b1;
      end
      default: ;
    endcase
  end

  assign commit = done && out_free;

  // event execution: queue edits, dispatch and status
  always_comb begin
    logic          disp;
    logic [TW-1:0] pop_id;
    logic [TW-1:0] fwd;
    ready_head_d  = ready_head_q;
    ready_tail_d  = ready_tail_q;
    ready_empty_d = ready_empty_q;
    cur_d         = cur_q;
    cur_valid_d   = cur_valid_q;
    halted_d      = halted_q;
    live_d        = live_q;
    sem_wd        = sem_cur;
    sem_we        = 1'b0;
    lk_we         = 1'b0;
    lk_wa         = ready_tail_q;
    lk_wd         = '0;
    status_c      = fts_pkg::STAT_OK;
    sw_c          = 1'b0;
    disp          = 1'b0;
    pop_id        = '0;
    fwd           = '0;

    if (halted_q) begin
      status_c = fts_pkg::STAT_HALTED;
    end else begin
      case (fts_pkg::op_e'(ev_op_q))
        fts_pkg::OP_LAUNCH: begin
          if (ev_tid_ok_q) begin
            if (live_q[ev_tid_q]) begin
              status_c = fts_pkg::STAT_DUPLICATE;
            end else begin
              live_d[ev_tid_q] = 1'b1;
              if (ready_empty_q) begin
                ready_head_d  = ev_tid_q;
                ready_empty_d = 1'b0;
              end else begin
                lk_we = 1'b1;
                lk_wa = ready_tail_q;
                lk_wd = ev_tid_q;
              end
              ready_tail_d = ev_tid_q;
            end
          end
        end
        fts_pkg::OP_START: begin
          if (!cur_valid_q) begin
            if (ready_empty_q) begin
              status_c    = fts_pkg::STAT_NO_THREADS;
              halted_d    = 1'b1;
            end else begin
              disp = 1'b1;
            end
          end
        end
        fts_pkg::OP_RELINQ: begin
          if (cur_valid_q) begin
            if (ready_empty_q) begin
              ready_head_d  = cur_q;
              ready_empty_d = 1'b0;
            end else begin
              lk_we = 1'b1;
              lk_wa = ready_tail_q;
              lk_wd = cur_q;
            end
            ready_tail_d = cur_q;
            disp         = 1'b1;
          end
        end
        fts_pkg::OP_EXIT: begin
          if (cur_valid_q) begin
            live_d[cur_q] = 1'b0;
            cur_valid_d   = 1'b0;
            if (ready_empty_q) begin
              status_c = fts_pkg::STAT_READY_EMPTY;
              halted_d = 1'b1;
            end else begin
              disp = 1'b1;
            end
          end
        end
        fts_pkg::OP_WAIT: begin
          if (ev_si_ok_q) begin
            if (sem_cur.count != '0) begin
              sem_wd.count = sem_cur.count - CW'(1);
              sem_we       = 1'b1;
            end else if (cur_valid_q) begin
              // block the running thread on the semaphore queue
              if (sem_cur.empty) begin
                sem_wd.head  = cur_q;
                sem_wd.empty = 1'b0;
              end else begin
                lk_we = 1'b1;
                lk_wa = sem_cur.tail;
                lk_wd = cur_q;
              end
              sem_wd.tail = cur_q;
              sem_we      = 1'b1;
              cur_valid_d = 1'b0;
              if (ready_empty_q) begin
                status_c = fts_pkg::STAT_DEADLOCK;
                halted_d = 1'b1;
              end else begin
                disp = 1'b1;
              end
            end
          end
        end
        fts_pkg::OP_SIGNAL: begin
          if (ev_si_ok_q) begin
            if (!sem_cur.empty) begin
              // move the first waiter to the ready tail
              pop_id = sem_cur.head;
              if (sem_cur.head == sem_cur.tail) sem_wd.empty = 1'b1;
              else sem_wd.head = link_rdata_q;
              sem_we = 1'b1;
              if (ready_empty_q) begin
                ready_head_d  = pop_id;
                ready_empty_d = 1'b0;
              end else begin
                lk_we = 1'b1;
                lk_wa = ready_tail_q;
                lk_wd = pop_id;
              end
              ready_tail_d = pop_id;
            end else if (sem_cur.count == '1) begin
              status_c = fts_pkg::STAT_SATURATED;
            end else begin
              sem_wd.count = sem_cur.count + CW'(1);
              sem_we       = 1'b1;
            end
          end
        end
        fts_pkg::OP_INIT: begin
          if (ev_si_ok_q) begin
            if (33'(ev_iv_q) > 33'({CW{1'b1}})) begin
              sem_wd.count = '1;
              status_c     = fts_pkg::STAT_SATURATED;
            end else begin
              sem_wd.count = CW'(ev_iv_q);
            end
            sem_wd.head  = '0;
            sem_wd.tail  = '0;
            sem_wd.empty = 1'b1;
            sem_we       = 1'b1;
          end
        end
        default: ;
      endcase

      // dispatch the ready head, forwarding a link written by this event
      if (disp) begin
        fwd = (lk_we && (lk_wa == ready_head_q)) ? lk_wd : link_rdata_q;
        sw_c = !cur_valid_d || (cur_q != ready_head_d);
        cur_d = ready_head_d;
        if (ready_head_d == ready_tail_d) ready_empty_d = 1'b1;
        else ready_head_d = fwd;
        cur_valid_d = 1'b1;
      end

      if (halted_d) cur_valid_d = 1'b0;
    end
  end

  // link ram
  always_ff @(posedge clk_i) begin
    if (commit && lk_we) link_mem[lk_wa] <= lk_wd;
    if (link_re) link_rdata_q <= link_mem[link_raddr];
  end

  // semaphore ram
  always_ff @(posedge clk_i) begin
    if (commit && sem_we) sem_mem[ev_si_q] <= sem_wd;
    if (sem_re) begin
      sem_rdata_q <= sem_mem[sem_raddr];
      sem_hit_q   <= sem_vld_q[sem_raddr];
    end
  end

  // event capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ev_op_q     <= evt_i.opcode;
      ev_tid_q    <= TW'(evt_i.thread_id);
      ev_tid_ok_q <= in_tid_ok;
      ev_si_q     <= SW'(evt_i.sem_index);
      ev_si_ok_q  <= in_si_ok;
      ev_iv_q     <= evt_i.init_value;
    end
  end

  // control and scheduler state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= fts_pkg::S_IDLE;
      ready_head_q  <= '0;
      ready_tail_q  <= '0;
      ready_empty_q <= 1'b1;
      cur_q         <= '0;
      cur_valid_q   <= 1'b0;
      halted_q      <= 1'b0;
      live_q        <= '0;
      sem_vld_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        ready_head_q  <= ready_head_d;
        ready_tail_q  <= ready_tail_d;
        ready_empty_q <= ready_empty_d;
        cur_q         <= cur_d;
        cur_valid_q   <= cur_valid_d;
        halted_q      <= halted_d;
        live_q        <= live_d;
        if (sem_we) sem_vld_q[ev_si_q] <= 1'b1;
        out_valid_q   <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_thread_q <= cur_valid_d ? TidW'(cur_d) : '0;
      out_rvalid_q <= cur_valid_d;
      out_sw_q     <= sw_c;
      out_status_q <= status_c;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.running_thread = out_thread_q;
  assign res_o.running_valid  = out_rvalid_q;
  assign res_o.switched       = out_sw_q;
  assign res_o.status         = out_status_q;

endmodule

`default_nettype wire
